[rtl/neighbor_cache_table_top_macros.svh]
// Assertion helpers for the checker file
`ifndef NEIGHBOR_CACHE_TABLE_TOP_MACROS_SVH
`define NEIGHBOR_CACHE_TABLE_TOP_MACROS_SVH

// Checked only outside reset
`define NCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define NCT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/nct_pkg.sv]
package nct_pkg;

   localparam int DEF_SLOTS   = 64;
   localparam int NUM_CLASSES = 7;
   localparam int REQ_W       = 232;
   localparam int RSP_W       = 72;

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_DELETE = 3'd1,
      MODE_LOOKUP = 3'd2,
      MODE_FLUSH  = 3'd3,
      MODE_SWEEP  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STS_DONE      = 2'd0,
      STS_REFRESHED = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam logic CSR_TTL  = 1'b0;
   localparam logic CSR_MASK = 1'b1;

   localparam logic [2:0] CLASS_NONE = 3'd7;

endpackage

[rtl/neighbor_cache_table_top.sv]
// Each item walks every slot once: one slot read per cycle from the slot memory.
// The result is registered into the output stage once the walk is done.
// Items are taken one at a time: a new one is accepted only back in the idle state.
// Reset (synchronous, active high) clears all valid bits, occupancy, the configuration
// registers and the output valid at once; no clearing pass is needed.
module neighbor_cache_table_top #(
   parameter int TABLE_SLOTS = nct_pkg::DEF_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // source_class[2:0], is_ipv6[3], addr_high[67:4], addr_low[131:68],
   // mac_in[179:132], interface_index[195:180], time_now[227:196], zero[231:228]
   input  logic [nct_pkg::REQ_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [2:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // mac_out[47:0], found_class[50:48], removed_count[57:51], occupancy[64:58],
   // zero[71:65]
   output logic [nct_pkg::RSP_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]                rsp_tuser,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);

   // slot memories
   logic [63:0] mem_hi    [TABLE_SLOTS];
   logic [63:0] mem_lo    [TABLE_SLOTS];
   logic        mem_v6    [TABLE_SLOTS];
   logic [2:0]  mem_cls   [TABLE_SLOTS];
   logic [47:0] mem_mac   [TABLE_SLOTS];
   logic [15:0] mem_ifx   [TABLE_SLOTS];
   logic [31:0] mem_stamp [TABLE_SLOTS];

   logic [63:0] r_hi_ff;
   logic [63:0] r_lo_ff;
   logic        r_v6_ff;
   logic [2:0]  r_cls_ff;
   logic [47:0] r_mac_ff;
   logic [15:0] r_ifx_ff;
   logic [31:0] r_stamp_ff;

   logic          ent_we;
   logic          stamp_we;
   logic [SW-1:0] wr_addr;
   logic [SW-1:0] rd_addr;

   nct_pkg::state_type state_ff, state_in;
   nct_pkg::mode_type  mode_ff;
   logic [2:0]  cls_ff;
   logic        v6_ff;
   logic [63:0] hi_ff;
   logic [63:0] lo_ff;
   logic [47:0] mac_ff;
   logic [15:0] ifx_ff;
   logic [31:0] now_ff;

   logic [31:0] ttl_ff;
   logic [6:0]  mask_ff;

   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pv_ff, pv_in;
   logic [SW-1:0] pidx_ff, pidx_in;

   logic          hit_ok_ff, hit_ok_in;
   logic [SW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_ok_ff, free_ok_in;
   logic [SW-1:0] free_idx_ff, free_idx_in;
   logic          best_ok_ff, best_ok_in;
   logic [2:0]    best_cls_ff, best_cls_in;
   logic [47:0]   best_mac_ff, best_mac_in;
   logic [CW-1:0] rem_ff, rem_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_sts_ff, rsp_sts_in;
   logic [47:0] rsp_mac_ff, rsp_mac_in;
   logic [2:0]  rsp_cls_ff, rsp_cls_in;
   logic [6:0]  rsp_rem_ff, rsp_rem_in;
   logic [6:0]  rsp_occ_ff, rsp_occ_in;

   logic        accept;
   logic        out_free;
   logic        slot_live;
   logic        addr_eq;
   logic        key_hit;
   logic        lk_hit;
   logic        flush_hit;
   logic        sweep_hit;
   logic [32:0] age;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == nct_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_addr    = cnt_ff[SW-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff  <= '0;
         mask_ff <= '0;
      end else if (csr_we) begin
         case (csr_index[0])
            nct_pkg::CSR_TTL:  ttl_ff  <= csr_wdata;
            nct_pkg::CSR_MASK: mask_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= nct_pkg::mode_type'(req_tuser);
         cls_ff  <= req_tdata[2:0];
         v6_ff   <= req_tdata[3];
         hi_ff   <= req_tdata[67:4];
         lo_ff   <= req_tdata[131:68];
         mac_ff  <= req_tdata[179:132];
         ifx_ff  <= req_tdata[195:180];
         now_ff  <= req_tdata[227:196];
      end
   end

   // slot memory: one read and one write port
   always_ff @(posedge clock) begin
      r_hi_ff    <= mem_hi[rd_addr];
      r_lo_ff    <= mem_lo[rd_addr];
      r_v6_ff    <= mem_v6[rd_addr];
      r_cls_ff   <= mem_cls[rd_addr];
      r_mac_ff   <= mem_mac[rd_addr];
      r_ifx_ff   <= mem_ifx[rd_addr];
      r_stamp_ff <= mem_stamp[rd_addr];
      if (ent_we) begin
         mem_hi[wr_addr]  <= hi_ff;
         mem_lo[wr_addr]  <= lo_ff;
         mem_v6[wr_addr]  <= v6_ff;
         mem_cls[wr_addr] <= cls_ff;
         mem_mac[wr_addr] <= mac_ff;
         mem_ifx[wr_addr] <= ifx_ff;
      end
      if (stamp_we) begin
         mem_stamp[wr_addr] <= now_ff;
      end
   end

   // per-slot compares on the registered read data
   assign slot_live = pv_ff && valid_ff[pidx_ff];
   assign addr_eq   = r_v6_ff ? (r_hi_ff == hi_ff && r_lo_ff == lo_ff)
                              : (r_lo_ff[31:0] == lo_ff[31:0]);
   assign key_hit   = slot_live && (r_v6_ff == v6_ff) && addr_eq && (r_cls_ff == cls_ff);
   assign lk_hit    = slot_live && (r_v6_ff == v6_ff) && addr_eq &&
                      (r_cls_ff != nct_pkg::CLASS_NONE) &&
                      (!best_ok_ff || r_cls_ff < best_cls_ff);
   assign flush_hit = slot_live && (r_cls_ff == cls_ff) && (r_ifx_ff == ifx_ff);
   // signed age, no wrap
   assign age       = {1'b0, now_ff} - {1'b0, r_stamp_ff};
   assign sweep_hit = slot_live && (r_cls_ff != nct_pkg::CLASS_NONE) &&
                      mask_ff[r_cls_ff] && ($signed(age) >= $signed({1'b0, ttl_ff}));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      hit_ok_in    = hit_ok_ff;
      hit_idx_in   = hit_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      best_ok_in   = best_ok_ff;
      best_cls_in  = best_cls_ff;
      best_mac_in  = best_mac_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sts_in   = rsp_sts_ff;
      rsp_mac_in   = rsp_mac_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_occ_in   = rsp_occ_ff;
      ent_we       = 1'b0;
      stamp_we     = 1'b0;
      wr_addr      = hit_idx_ff;

      case (state_ff)
         nct_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in     = '0;
               hit_ok_in  = 1'b0;
               free_ok_in = 1'b0;
               best_ok_in = 1'b0;
               rem_in     = '0;
               state_in   = nct_pkg::ST_SCAN;
            end
         end

         nct_pkg::ST_SCAN: begin
            // issue one slot read a cycle
            if (cnt_ff < CW'(TABLE_SLOTS)) begin
               pv_in   = 1'b1;
               pidx_in = rd_addr;
               cnt_in  = cnt_ff + CW'(1);
            end else if (!pv_ff) begin
               state_in = nct_pkg::ST_FINISH;
            end
            // evaluate the slot read last cycle
            if (pv_ff) begin
               if (key_hit && !hit_ok_ff) begin
                  hit_ok_in  = 1'b1;
                  hit_idx_in = pidx_ff;
               end
               if (!valid_ff[pidx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = pidx_ff;
               end
               if (mode_ff == nct_pkg::MODE_LOOKUP && lk_hit) begin
                  best_ok_in  = 1'b1;
                  best_cls_in = r_cls_ff;
                  best_mac_in = r_mac_ff;
               end
               if ((mode_ff == nct_pkg::MODE_FLUSH && flush_hit) ||
                   (mode_ff == nct_pkg::MODE_SWEEP && sweep_hit)) begin
                  valid_in[pidx_ff] = 1'b0;
                  rem_in            = rem_ff + CW'(1);
               end
            end
         end

         nct_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sts_in   = nct_pkg::STS_DONE;
               rsp_mac_in   = '0;
               rsp_cls_in   = '0;
               rsp_rem_in   = '0;
               state_in     = nct_pkg::ST_IDLE;
               case (mode_ff)
                  nct_pkg::MODE_ADD: begin
                     if (hit_ok_ff) begin
                        stamp_we   = 1'b1;
                        rsp_sts_in = nct_pkg::STS_REFRESHED;
                     end else if (free_ok_ff) begin
                        wr_addr            = free_idx_ff;
                        ent_we             = 1'b1;
                        stamp_we           = 1'b1;
                        valid_in[free_idx_ff] = 1'b1;
                        occ_in             = occ_ff + CW'(1);
                     end else begin
                        rsp_sts_in = nct_pkg::STS_FULL;
                     end
                  end
                  nct_pkg::MODE_DELETE: begin
                     if (hit_ok_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        occ_in               = occ_ff - CW'(1);
                        rsp_rem_in           = 7'd1;
                     end else begin
                        rsp_sts_in = nct_pkg::STS_NOT_FOUND;
                     end
                  end
                  nct_pkg::MODE_LOOKUP: begin
                     if (best_ok_ff) begin
                        rsp_mac_in = best_mac_ff;
                        rsp_cls_in = best_cls_ff;
                     end else begin
                        rsp_sts_in = nct_pkg::STS_NOT_FOUND;
                     end
                  end
                  nct_pkg::MODE_FLUSH, nct_pkg::MODE_SWEEP: begin
                     occ_in     = occ_ff - rem_ff;
                     rsp_rem_in = 7'(rem_ff);
                  end
                  default: ;
               endcase
               rsp_occ_in = 7'(occ_in);
            end
         end

         default: state_in = nct_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nct_pkg::ST_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan bookkeeping and result payload
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pidx_ff     <= pidx_in;
      hit_ok_ff   <= hit_ok_in;
      hit_idx_ff  <= hit_idx_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      best_ok_ff  <= best_ok_in;
      best_cls_ff <= best_cls_in;
      best_mac_ff <= best_mac_in;
      rem_ff      <= rem_in;
      rsp_sts_ff  <= rsp_sts_in;
      rsp_mac_ff  <= rsp_mac_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sts_ff;
   assign rsp_tdata  = {7'd0, rsp_occ_ff, rsp_rem_ff, rsp_cls_ff, rsp_mac_ff};

endmodule

[rtl/nct_checker.sv]
`include "neighbor_cache_table_top_macros.svh"

module nct_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [nct_pkg::RSP_W-1:0] rsp_tdata,
   input logic [1:0]                rsp_tuser
);

   // a stalled result stays offered
   `NCT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   // the block takes one item at a time
   `NCT_ASSERT(a_busy_after_accept, req_tvalid && req_tready |=> !req_tready, "second item taken while busy")
   // a miss carries no MAC
   `NCT_ASSERT(a_miss_no_mac, rsp_tvalid && rsp_tuser == nct_pkg::STS_NOT_FOUND |-> rsp_tdata[47:0] == 48'd0, "MAC on miss")
   // nothing comes out right after reset
   `NCT_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_tvalid, "result after reset")

endmodule

bind neighbor_cache_table_top nct_checker u_nct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
